FILE: src/boundary_tuple_intern_table_assert.svh
// Assertion macros for the boundary tuple intern table.
`ifndef BOUNDARY_TUPLE_INTERN_TABLE_ASSERT_SVH
`define BOUNDARY_TUPLE_INTERN_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define BTIT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("btit assertion failed");

// Next-cycle implication, disabled while in reset.
`define BTIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("btit assertion failed");

`endif

FILE: src/btit_pkg.sv
// Types and codes shared by the boundary tuple intern table.
package btit_pkg;

	localparam logic [1:0] OP_INTERN = 2'd0;
	localparam logic [1:0] OP_FIND   = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	localparam logic [2:0] ST_FOUND     = 3'd0;
	localparam logic [2:0] ST_APPENDED  = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_RANGE     = 3'd4;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] outer_material;
		logic [7:0] outer_surface;
		logic [7:0] inner_surface;
		logic [7:0] inner_material;
		logic [6:0] entry_position;
	} item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [6:0] position;
		logic [7:0] read_outer_material;
		logic [7:0] read_outer_surface;
		logic [7:0] read_inner_surface;
		logic [7:0] read_inner_material;
		logic [7:0] entry_count;
	} result_t;

endpackage

FILE: src/boundary_tuple_intern_table.sv
// Top level of the boundary tuple intern table: sequencer and key memory.
//
// Usage:
//   An item is taken on item at a rising edge with start high and busy low.
//   Opcode intern searches the stored keys in insertion order and returns the
//   first matching position, or appends the key if the table is not full; find
//   searches only; read returns the four parts stored at entry_position.
//   Each item gives one result on result, valid for exactly one cycle while
//   done is high. The receiver cannot stall; no result is ever held back.
// Sequencing:
//   Keys live in a single-port-read, single-port-write synchronous memory with
//   a registered read. A search reads one stored key per cycle from entry 0
//   and stops at the first hit or after the last stored key. A read waits in
//   S_RDWAIT for the registered key; an out-of-range read, an invalid opcode
//   or a search of an empty table is answered straight from idle.
//   One item is worked on at a time; busy drops in the cycle the result is
//   shown, so the next item can be taken at the edge that takes the result.
// Reset:
//   arst_n clears the entry count and sequencer; memory contents are left as
//   they are, since only entries below the count are ever used.
module boundary_tuple_intern_table #(
	parameter int TABLE_DEPTH = 128,
	parameter int PART_WIDTH  = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  btit_pkg::item_t   item,
	output logic              done,
	output btit_pkg::result_t result
);

	localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW   = $clog2(TABLE_DEPTH + 1);
	localparam int CMPW = (CW > 7) ? CW : 7;
	localparam int KW   = 4 * PART_WIDTH;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_RDWAIT = 3'b100
	} state_t;

	state_t            state_q, state_d;
	logic [AW-1:0]     idx_q, idx_d;
	logic [CW-1:0]     count_q, count_d;
	logic [1:0]        op_q;
	logic [KW-1:0]     key_q;
	logic [KW-1:0]     key_in;
	logic              done_q, done_d;
	btit_pkg::result_t res_q, res_d;

	// key memory
	logic [KW-1:0]     key_mem [TABLE_DEPTH];
	logic [KW-1:0]     rd_data_q;
	logic [AW-1:0]     rd_addr;
	logic              mem_we;
	logic [AW-1:0]     wr_addr;
	logic [KW-1:0]     wr_data;

	logic              accept;
	logic              last;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

	// Parts packed low to high: outer material first.
	assign key_in = {PART_WIDTH'(16'(item.inner_material)),
		PART_WIDTH'(16'(item.inner_surface)),
		PART_WIDTH'(16'(item.outer_surface)),
		PART_WIDTH'(16'(item.outer_material))};

	assign last = ((CW'(idx_q) + CW'(1)) == count_q);

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		count_d = count_q;
		done_d  = 1'b0;
		res_d   = '0;
		mem_we  = 1'b0;
		wr_addr = AW'(count_q);
		wr_data = key_q;
		rd_addr = '0;

		unique case (state_q)
			S_IDLE: begin
				if (item.opcode == btit_pkg::OP_READ) begin
					rd_addr = AW'(item.entry_position);
				end
				if (accept) begin
					unique case (item.opcode) inside
						btit_pkg::OP_INTERN, btit_pkg::OP_FIND: begin
							idx_d = '0;
							if (count_q == '0) begin
								// empty table: nothing to scan
								done_d = 1'b1;
								if (item.opcode == btit_pkg::OP_INTERN) begin
									mem_we       = 1'b1;
									wr_data      = key_in;
									count_d      = count_q + CW'(1);
									res_d.status = btit_pkg::ST_APPENDED;
								end else begin
									res_d.status = btit_pkg::ST_NOT_FOUND;
								end
							end else begin
								state_d = S_SCAN;
							end
						end
						btit_pkg::OP_READ: begin
							if (CMPW'(item.entry_position) < CMPW'(count_q)) begin
								idx_d   = AW'(item.entry_position);
								state_d = S_RDWAIT;
							end else begin
								done_d       = 1'b1;
								res_d.status = btit_pkg::ST_RANGE;
							end
						end
						default: begin
							done_d       = 1'b1;
							res_d.status = btit_pkg::ST_RANGE;
						end
					endcase
				end
			end
			S_SCAN: begin
				// rd_data_q holds entry idx_q; fetch the next one meanwhile
				rd_addr = AW'(CW'(idx_q) + CW'(1));
				if (rd_data_q == key_q) begin
					done_d         = 1'b1;
					state_d        = S_IDLE;
					res_d.status   = btit_pkg::ST_FOUND;
					res_d.position = 7'(idx_q);
				end else if (last) begin
					done_d  = 1'b1;
					state_d = S_IDLE;
					if (op_q == btit_pkg::OP_FIND) begin
						res_d.status = btit_pkg::ST_NOT_FOUND;
					end else if (count_q == CW'(TABLE_DEPTH)) begin
						res_d.status = btit_pkg::ST_FULL;
					end else begin
						mem_we         = 1'b1;
						count_d        = count_q + CW'(1);
						res_d.status   = btit_pkg::ST_APPENDED;
						res_d.position = 7'(count_q);
					end
				end else begin
					idx_d = idx_q + AW'(1);
				end
			end
			S_RDWAIT: begin
				done_d                    = 1'b1;
				state_d                   = S_IDLE;
				res_d.status              = btit_pkg::ST_FOUND;
				res_d.position            = 7'(idx_q);
				res_d.read_outer_material = 8'(rd_data_q[0*PART_WIDTH +: PART_WIDTH]);
				res_d.read_outer_surface  = 8'(rd_data_q[1*PART_WIDTH +: PART_WIDTH]);
				res_d.read_inner_surface  = 8'(rd_data_q[2*PART_WIDTH +: PART_WIDTH]);
				res_d.read_inner_material = 8'(rd_data_q[3*PART_WIDTH +: PART_WIDTH]);
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		res_d.entry_count = 8'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		res_q <= res_d;
		if (accept) begin
			op_q  <= item.opcode;
			key_q <= key_in;
		end
	end

	// Writes land before any later item can issue a read, so no forwarding.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= key_mem[rd_addr];
	end

`include "boundary_tuple_intern_table_assert.svh"

	`BTIT_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(TABLE_DEPTH))
	`BTIT_ASSERT_NOW(a_scan_in_range, clk, arst_n, state_q == S_SCAN, CW'(idx_q) < count_q)
	`BTIT_ASSERT_NOW(a_write_not_full, clk, arst_n, mem_we, count_q < CW'(TABLE_DEPTH))
	`BTIT_ASSERT_NEXT(a_accept_progress, clk, arst_n, accept, done_q || busy)
	`BTIT_ASSERT_NOW(a_done_idle, clk, arst_n, done_q, state_q == S_IDLE)

endmodule

FILE: sim/boundary_tuple_intern_table_test.sv
// Self-checking testbench for the boundary tuple intern table.
`timescale 1ns / 100ps

module boundary_tuple_intern_table_test;

	localparam int TABLE_DEPTH    = 128;
	localparam int RANDOM_ITEMS   = 1325;
	localparam int WATCHDOG_LIMIT = 4000;

	// The opcode field allows a fourth value that the package leaves unnamed.
	localparam logic [1:0] OP_INVALID = 2'd3;

	// Sender pacing per stretch of the run: idle percentage picked by pace.
	localparam int PACE_LIGHT = 0;
	localparam int PACE_HEAVY = 1;
	localparam int PACE_NONE  = 2;

	// One key: outer material, outer surface, inner surface, inner material.
	typedef struct packed {
		logic [7:0] outer_material;
		logic [7:0] outer_surface;
		logic [7:0] inner_surface;
		logic [7:0] inner_material;
	} tuple_t;

	// A queued item plus how the driver should present it.
	typedef struct {
		btit_pkg::item_t payload;
		int              pace;
		bit              drain_first;
	} request_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	btit_pkg::item_t   item = '0;
	logic              busy;
	logic              done;
	btit_pkg::result_t result;

	boundary_tuple_intern_table uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	// Items waiting to be driven, and results owed by the block, oldest first.
	request_t          queued_requests[$];
	btit_pkg::result_t awaited_results[$];

	// Shadow of the table as the block should hold it.
	tuple_t held_keys [0:TABLE_DEPTH-1];
	int     held_count = 0;

	int items_taken = 0;   // driver side only
	int results_seen = 0;  // updated with NBA so the driver reads a settled value
	int mismatch_count = 0;
	int quiet_cycles = 0;

	request_t next_req;

	initial begin
		forever #1 clk = ~clk;
	end

	// Applies one item to the shadow table and returns the result it owes.
	// Search is first-match in insertion order; an all-ones part is just a value.
	function automatic btit_pkg::result_t intern_predict(input btit_pkg::item_t req);
		btit_pkg::result_t res;
		tuple_t            probe;
		int                hit;
		res = '0;
		res.status = btit_pkg::ST_RANGE;
		probe = {req.outer_material, req.outer_surface, req.inner_surface,
			req.inner_material};
		hit = -1;
		if (req.opcode == btit_pkg::OP_INTERN || req.opcode == btit_pkg::OP_FIND) begin
			for (int i = 0; i < held_count; i++) begin
				if (hit < 0 && held_keys[i] == probe)
					hit = i;
			end
			if (hit >= 0) begin
				res.status = btit_pkg::ST_FOUND;
				res.position = hit[6:0];
			end else if (req.opcode == btit_pkg::OP_FIND) begin
				res.status = btit_pkg::ST_NOT_FOUND;
			end else if (held_count >= TABLE_DEPTH) begin
				// full table: nothing stored, position stays zero
				res.status = btit_pkg::ST_FULL;
			end else begin
				held_keys[held_count] = probe;
				res.status = btit_pkg::ST_APPENDED;
				res.position = held_count[6:0];
				held_count++;
			end
		end else if (req.opcode == btit_pkg::OP_READ) begin
			// at or past the count is out of range; unwritten slots never reach here
			if (int'(req.entry_position) < held_count) begin
				res.status = btit_pkg::ST_FOUND;
				res.position = req.entry_position;
				res.read_outer_material = held_keys[req.entry_position].outer_material;
				res.read_outer_surface  = held_keys[req.entry_position].outer_surface;
				res.read_inner_surface  = held_keys[req.entry_position].inner_surface;
				res.read_inner_material = held_keys[req.entry_position].inner_material;
			end
		end
		// the invalid opcode falls through with the out-of-range result
		res.entry_count = held_count[7:0];
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("%0t ns: %s", $time, msg);
	endtask

	task automatic add_request(input logic [1:0] op, input tuple_t key,
			input logic [6:0] pos, input int pace, input bit drain_first);
		request_t req;
		req.payload.opcode = op;
		req.payload.outer_material = key.outer_material;
		req.payload.outer_surface  = key.outer_surface;
		req.payload.inner_surface  = key.inner_surface;
		req.payload.inner_material = key.inner_material;
		req.payload.entry_position = pos;
		req.pace = pace;
		req.drain_first = drain_first;
		queued_requests = {queued_requests, req};
	endtask

	// Random key; parts are often the all-ones "unset" value.
	function automatic tuple_t random_key();
		tuple_t key;
		key = $urandom();
		if ($urandom_range(0, 5) == 0) key.outer_material = '1;
		if ($urandom_range(0, 5) == 0) key.outer_surface  = '1;
		if ($urandom_range(0, 5) == 0) key.inner_surface  = '1;
		if ($urandom_range(0, 5) == 0) key.inner_material = '1;
		return key;
	endfunction

	function automatic int idle_percent(input int pace);
		case (pace)
			PACE_LIGHT: return 24;
			PACE_HEAVY: return 79;
			default:    return 0;
		endcase
	endfunction

	// Driver: records the item taken at this edge, then decides what start and
	// item hold for the next cycle. At most one NBA per signal per edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
		end else begin
			if (start && !busy) begin
				awaited_results = {awaited_results, intern_predict(item)};
				items_taken++;
			end
			if (!start || !busy) begin
				if (queued_requests.size() != 0) begin
					next_req = queued_requests[0];
					// a drain item holds off until every owed result is back
					if ((next_req.drain_first && items_taken != results_seen) ||
							$urandom_range(0, 99) < idle_percent(next_req.pace)) begin
						start <= 1'b0;
					end else begin
						start <= 1'b1;
						item <= next_req.payload;
						void'(queued_requests.pop_front());
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: the block cannot be stalled, so every done edge carries a result.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_seen <= 0;
		end else if (done) begin
			results_seen <= results_seen + 1;
			if (awaited_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing owed, status %0d",
					result.status));
			end else begin : compare
				btit_pkg::result_t want;
				want = awaited_results.pop_front();
				if (result.status !== want.status)
					report_mismatch($sformatf("status: got %0d, expected %0d",
						result.status, want.status));
				if (result.position !== want.position)
					report_mismatch($sformatf("position: got %0d, expected %0d",
						result.position, want.position));
				if (result.read_outer_material !== want.read_outer_material)
					report_mismatch($sformatf("read_outer_material: got %0d, expected %0d",
						result.read_outer_material, want.read_outer_material));
				if (result.read_outer_surface !== want.read_outer_surface)
					report_mismatch($sformatf("read_outer_surface: got %0d, expected %0d",
						result.read_outer_surface, want.read_outer_surface));
				if (result.read_inner_surface !== want.read_inner_surface)
					report_mismatch($sformatf("read_inner_surface: got %0d, expected %0d",
						result.read_inner_surface, want.read_inner_surface));
				if (result.read_inner_material !== want.read_inner_material)
					report_mismatch($sformatf("read_inner_material: got %0d, expected %0d",
						result.read_inner_material, want.read_inner_material));
				if (result.entry_count !== want.entry_count)
					report_mismatch($sformatf("entry_count: got %0d, expected %0d",
						result.entry_count, want.entry_count));
			end
		end
	end

	// Watchdog: a long silence with no item taken and no result is a hang.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		tuple_t     key;
		tuple_t     issued_keys[$];
		int         fill_estimate;
		int         pick;
		int         pace;
		bit         drain;
		logic [1:0] op;
		logic [6:0] pos;

		fill_estimate = 0;

		// Directed: empty-table cases, both extremes of every part, all opcodes.
		add_request(btit_pkg::OP_READ,   '0, 7'd0,   PACE_LIGHT, 1'b0); // read of empty
		add_request(btit_pkg::OP_FIND,   '0, 7'd0,   PACE_LIGHT, 1'b0); // search of empty
		add_request(OP_INVALID,          '1, 7'd127, PACE_LIGHT, 1'b0);
		add_request(btit_pkg::OP_INTERN, '0, 7'd127, PACE_LIGHT, 1'b0); // append at 0
		add_request(btit_pkg::OP_INTERN, '1, 7'd0,   PACE_LIGHT, 1'b0); // all parts unset
		add_request(btit_pkg::OP_INTERN, '0, 7'd0,   PACE_LIGHT, 1'b0); // dup of entry 0
		add_request(btit_pkg::OP_FIND,   '1, 7'd0,   PACE_LIGHT, 1'b0);
		add_request(btit_pkg::OP_FIND,   32'h00ff_00ff, 7'd0, PACE_LIGHT, 1'b0); // miss
		add_request(btit_pkg::OP_READ,   '0, 7'd1,   PACE_LIGHT, 1'b0);
		add_request(btit_pkg::OP_READ,   '0, 7'd2,   PACE_LIGHT, 1'b0); // at the count
		add_request(btit_pkg::OP_READ,   '0, 7'd127, PACE_LIGHT, 1'b0);
		add_request(btit_pkg::OP_INTERN, 32'h0102_0480, 7'd0, PACE_LIGHT, 1'b0);
		add_request(btit_pkg::OP_INTERN, 32'h0102_0481, 7'd0, PACE_LIGHT, 1'b0); // one apart
		add_request(btit_pkg::OP_FIND,   32'h0102_0480, 7'd0, PACE_LIGHT, 1'b1);
		add_request(OP_INVALID,          '0, 7'd0,   PACE_LIGHT, 1'b0);
		add_request(btit_pkg::OP_READ,   '0, 7'd3,   PACE_LIGHT, 1'b0);
		add_request(btit_pkg::OP_READ,   '0, 7'd0,   PACE_LIGHT, 1'b0);
		issued_keys = {tuple_t'(32'h0000_0000), tuple_t'(32'hffff_ffff),
			tuple_t'(32'h0102_0480), tuple_t'(32'h0102_0481)};
		fill_estimate = 4;

		// Random: mostly hits and reads of live entries, with enough new keys
		// that the table fills and the full case gets exercised.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pace = (n * 3) / RANDOM_ITEMS;
			drain = (n % (RANDOM_ITEMS / 3) == 0) || ($urandom_range(0, 99) < 2);
			pick = $urandom_range(0, 99);
			key = random_key();
			pos = 7'($urandom());
			if (pick < 22) begin
				op = btit_pkg::OP_INTERN;
				issued_keys = {issued_keys, key};
				if (fill_estimate < TABLE_DEPTH)
					fill_estimate++;
			end else if (pick < 42) begin
				op = btit_pkg::OP_INTERN;
				key = issued_keys[$urandom_range(0, issued_keys.size() - 1)];
			end else if (pick < 52) begin
				op = btit_pkg::OP_FIND;
				key = issued_keys[$urandom_range(0, issued_keys.size() - 1)];
			end else if (pick < 60) begin
				op = btit_pkg::OP_FIND;
			end else if (pick < 94) begin
				op = btit_pkg::OP_READ;
				// mostly near the live range, including the first slot past it
				if ($urandom_range(0, 4) != 0)
					pos = 7'($urandom_range(0, (fill_estimate > 127) ? 127 : fill_estimate));
			end else begin
				op = OP_INVALID;
			end
			add_request(op, key, pos, pace, drain);
		end

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (queued_requests.size() != 0 || start || awaited_results.size() != 0)
			@(posedge clk);
		// anything arriving now was never owed
		repeat (TABLE_DEPTH + 8) @(posedge clk);

		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+src
src/btit_pkg.sv
src/boundary_tuple_intern_table.sv
sim/boundary_tuple_intern_table_test.sv
